### rtl/fan_curve_interpolator_assert.svh
// Assertion macros used by the fan curve top-level RTL.
// Include by bare file name; no other dependencies.
`ifndef FAN_CURVE_INTERPOLATOR_ASSERT_SVH
`define FAN_CURVE_INTERPOLATOR_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define FCI_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define FCI_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/fci_pkg.sv
// Types and constants for the fan curve interpolator.
// No dependencies; imported by every module of the block.
package fci_pkg;

    localparam int TEMP_W     = 12;
    localparam int SPEED_W    = 7;
    localparam int DUTY_W     = 9;
    localparam int REQ_W      = 10;
    localparam int CFG_W      = 60;
    localparam int CFG_IDX_W  = 3;
    localparam int MAX_POINTS = 5;

    localparam int DIFF_W = TEMP_W + 1;
    localparam int PROD_W = DIFF_W + SPEED_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int NUM_W  = PROD_W;
    localparam int DEN_W  = TEMP_W;
    localparam int Q_W    = 8;
    localparam int SCALE_W = 8;
    localparam int PCT_W  = 7;

    localparam logic [SCALE_W-1:0] SCALE_NUM = 8'd254;
    localparam logic [PCT_W-1:0]   PCT_FULL  = 7'd100;

    localparam logic [DUTY_W-1:0] DUTY_HOT  = 9'd254;
    localparam logic [DUTY_W-1:0] DUTY_COLD = 9'd256;
    localparam logic [DUTY_W-1:0] DUTY_MAX  = 9'd255;
    localparam logic [DUTY_W-1:0] DUTY_MIN  = 9'd1;

    localparam logic OP_SAMPLE   = 1'b0;
    localparam logic OP_MANUAL   = 1'b1;
    localparam logic MODE_MANUAL = 1'b0;
    localparam logic MODE_CURVE  = 1'b1;
    localparam logic INTERP_LINEAR = 1'b0;

    localparam logic [CFG_IDX_W-1:0] REG_FAN_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERP_MODE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_MIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_MAX     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_TEMPS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_SPEEDS = 3'd5;

    localparam logic signed [TEMP_W-1:0] SAFE_MIN_RST = 12'sd320;
    localparam logic signed [TEMP_W-1:0] SAFE_MAX_RST = 12'sd528;
    localparam logic [CFG_W-1:0]            TEMPS_RST  = 60'd128382283174936912;
    localparam logic [SPEED_W*MAX_POINTS-1:0] SPEEDS_RST = 35'd27022725258;

    typedef struct packed {
        logic                     op;
        logic signed [TEMP_W-1:0] temperature;
        logic [REQ_W-1:0]         requested_speed;
    } in_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              safety_override;
    } out_t;

    typedef struct packed {
        logic              fixed;
        logic [DUTY_W-1:0] duty;
        logic              ovr;
        logic              zero;
    } tag_t;

endpackage

### rtl/fci_div.sv
// Pipelined scale-and-divide unit: floor(num*254 / (den*100)), saturated to 255.
// Depends on fci_pkg; one radix-2 quotient bit per stage.
module fci_div
    import fci_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] in_num,
    input  logic [DEN_W-1:0] in_den,
    input  tag_t             in_tag,
    output logic             out_valid,
    output logic [Q_W-1:0]   out_q,
    output tag_t             out_tag
);

    localparam int NW = NUM_W + SCALE_W;
    localparam int DW = DEN_W + PCT_W;
    localparam int RW = DW + Q_W;

    logic          e_valid_reg;
    logic [NW-1:0] e_n_reg;
    logic [DW-1:0] e_d_reg;
    tag_t          e_tag_reg;

    logic          v_reg   [Q_W+1];
    logic [RW-1:0] rem_reg [Q_W+1];
    logic [DW-1:0] dv_reg  [Q_W+1];
    logic [Q_W-1:0] q_reg  [Q_W+1];
    logic          ovf_reg [Q_W+1];
    tag_t          tag_reg [Q_W+1];

    logic ovf_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
            v_reg[0]    <= 1'b0;
        end else if (en) begin
            e_valid_reg <= in_valid;
            v_reg[0]    <= e_valid_reg;
        end
    end

    assign ovf_next = ({{Q_W{1'b0}}, e_n_reg} >= {{(NW + Q_W - RW){1'b0}}, e_d_reg, {Q_W{1'b0}}});

    always_ff @(posedge aclk) begin
        if (en) begin
            e_n_reg    <= NW'(in_num) * NW'(SCALE_NUM);
            e_d_reg    <= DW'(in_den) * DW'(PCT_FULL);
            e_tag_reg  <= in_tag;
            rem_reg[0] <= e_n_reg[RW-1:0];
            dv_reg[0]  <= e_d_reg;
            q_reg[0]   <= '0;
            ovf_reg[0] <= ovf_next;
            tag_reg[0] <= e_tag_reg;
        end
    end

    for (genvar j = 0; j < Q_W; j++) begin : g_step
        localparam int BIT = Q_W - 1 - j;
        logic [RW-1:0] sh;
        logic          ge;

        assign sh = RW'(dv_reg[j]) << BIT;
        assign ge = (rem_reg[j] >= sh);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j+1] <= 1'b0;
            end else if (en) begin
                v_reg[j+1] <= v_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j+1] <= ge ? rem_reg[j] - sh : rem_reg[j];
                dv_reg[j+1]  <= dv_reg[j];
                q_reg[j+1]   <= q_reg[j] | (Q_W'(ge) << BIT);
                ovf_reg[j+1] <= ovf_reg[j];
                tag_reg[j+1] <= tag_reg[j];
            end
        end
    end

    assign out_valid = v_reg[Q_W];
    assign out_q     = ovf_reg[Q_W] ? '1 : q_reg[Q_W];
    assign out_tag   = tag_reg[Q_W];

endmodule

### rtl/fan_curve_interpolator.sv
// Each accepted transaction passes through stages A to D, the divider pipeline and the output register.
// Throughput: one transaction per cycle; a stalled output freezes the whole pipeline.
// Transactions that do not match the fan mode leave the pipeline with no result.
// Reset (aresetn low, synchronous) clears all valid bits and restores register defaults.
`include "fan_curve_interpolator_assert.svh"

module fan_curve_interpolator
    import fci_pkg::*;
#(
    parameter int CURVE_POINTS = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_t                  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_t                 m_data
);

    localparam int LAST = CURVE_POINTS - 1;

    logic                           fan_mode_reg;
    logic                           interp_mode_reg;
    logic signed [TEMP_W-1:0]       safe_min_reg;
    logic signed [TEMP_W-1:0]       safe_max_reg;
    logic [CFG_W-1:0]               curve_temps_reg;
    logic [SPEED_W*MAX_POINTS-1:0]  curve_speeds_reg;

    logic adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fan_mode_reg     <= MODE_CURVE;
            interp_mode_reg  <= INTERP_LINEAR;
            safe_min_reg     <= SAFE_MIN_RST;
            safe_max_reg     <= SAFE_MAX_RST;
            curve_temps_reg  <= TEMPS_RST;
            curve_speeds_reg <= SPEEDS_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FAN_MODE:     fan_mode_reg     <= cfg_wdata[0];
                REG_INTERP_MODE:  interp_mode_reg  <= cfg_wdata[0];
                REG_SAFE_MIN:     safe_min_reg     <= $signed(cfg_wdata[TEMP_W-1:0]);
                REG_SAFE_MAX:     safe_max_reg     <= $signed(cfg_wdata[TEMP_W-1:0]);
                REG_CURVE_TEMPS:  curve_temps_reg  <= cfg_wdata;
                REG_CURVE_SPEEDS: curve_speeds_reg <= cfg_wdata[SPEED_W*MAX_POINTS-1:0];
                default: ;
            endcase
        end
    end

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // stage A: mode filter, safety limits, breakpoint search
    logic signed [TEMP_W-1:0] pt [CURVE_POINTS];
    logic [SPEED_W-1:0]       sp [CURVE_POINTS];
    logic                     a_valid_next;
    logic signed [TEMP_W-1:0] a_tmin_next;
    logic signed [TEMP_W-1:0] a_tmax_next;
    logic [SPEED_W-1:0]       a_tg_next;
    logic [SPEED_W-1:0]       a_ms_next;
    tag_t                     a_tag_next;

    logic                     a_valid_reg;
    logic                     a_interp_reg;
    logic signed [TEMP_W-1:0] a_t_reg;
    logic signed [TEMP_W-1:0] a_tmin_reg;
    logic signed [TEMP_W-1:0] a_tmax_reg;
    logic [SPEED_W-1:0]       a_tg_reg;
    logic [SPEED_W-1:0]       a_ms_reg;
    tag_t                     a_tag_reg;

    always_comb begin
        for (int i = 0; i < CURVE_POINTS; i++) begin
            pt[i] = $signed(curve_temps_reg[TEMP_W*i +: TEMP_W]);
            sp[i] = curve_speeds_reg[SPEED_W*i +: SPEED_W];
        end
    end

    always_comb begin
        a_tmin_next = pt[0];
        a_tmax_next = pt[LAST];
        a_tg_next   = '0;
        a_ms_next   = PCT_FULL;
        for (int i = 0; i < CURVE_POINTS; i++) begin
            if (s_data.temperature >= pt[i]) begin
                a_tmin_next = pt[i];
                a_tg_next   = sp[i];
                a_ms_next   = (i == LAST) ? PCT_FULL : sp[(i == LAST) ? LAST : i + 1];
                a_tmax_next = pt[(i == LAST) ? LAST : i + 1];
            end
        end
    end

    always_comb begin
        a_valid_next = s_valid &&
            ((s_data.op == OP_SAMPLE && fan_mode_reg == MODE_CURVE) ||
             (s_data.op == OP_MANUAL && fan_mode_reg == MODE_MANUAL));
        a_tag_next = '0;
        if (s_data.temperature > safe_max_reg) begin
            a_tag_next.fixed = 1'b1;
            a_tag_next.duty  = DUTY_HOT;
            a_tag_next.ovr   = 1'b1;
        end else if (s_data.temperature < safe_min_reg) begin
            a_tag_next.fixed = 1'b1;
            a_tag_next.duty  = DUTY_COLD;
            a_tag_next.ovr   = 1'b1;
        end else if (s_data.op == OP_MANUAL) begin
            a_tag_next.fixed = 1'b1;
            if (REQ_W'(s_data.requested_speed) > REQ_W'(DUTY_MAX)) begin
                a_tag_next.duty = DUTY_MAX;
            end else if (s_data.requested_speed == '0) begin
                a_tag_next.duty = DUTY_MIN;
            end else begin
                a_tag_next.duty = DUTY_W'(s_data.requested_speed);
            end
        end
    end

    // stage B: differences and case selection
    logic                     b_valid_reg;
    logic                     b_simple_reg;
    logic [SPEED_W-1:0]       b_sval_reg;
    logic signed [DIFF_W-1:0] b_den_reg;
    logic signed [DIFF_W-1:0] b_dt_reg;
    logic signed [SPEED_W:0]  b_dms_reg;
    logic [SPEED_W-1:0]       b_tg_reg;
    tag_t                     b_tag_reg;

    // stage C: products
    logic                     c_valid_reg;
    logic                     c_simple_reg;
    logic [SPEED_W-1:0]       c_sval_reg;
    logic signed [DIFF_W-1:0] c_den_reg;
    logic signed [PROD_W-1:0] c_p1_reg;
    logic signed [PROD_W-1:0] c_p2_reg;
    tag_t                     c_tag_reg;

    // stage D: sum, sign fold, zero detect
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  sum_n;
    logic signed [DIFF_W-1:0] den_n;
    logic [NUM_W-1:0]         d_num_next;
    logic [DEN_W-1:0]         d_den_next;
    tag_t                     d_tag_next;

    logic                     d_valid_reg;
    logic [NUM_W-1:0]         d_num_reg;
    logic [DEN_W-1:0]         d_den_reg;
    tag_t                     d_tag_reg;

    always_comb begin
        sum   = SUM_W'(c_p1_reg) + SUM_W'(c_p2_reg);
        sum_n = c_den_reg[DIFF_W-1] ? -sum : sum;
        den_n = c_den_reg[DIFF_W-1] ? -c_den_reg : c_den_reg;
        d_tag_next = c_tag_reg;
        if (c_simple_reg) begin
            d_num_next      = NUM_W'(c_sval_reg);
            d_den_next      = DEN_W'(1);
            d_tag_next.zero = (c_sval_reg == '0);
        end else begin
            d_num_next      = sum_n[NUM_W-1:0];
            d_den_next      = den_n[DEN_W-1:0];
            d_tag_next.zero = (den_n == '0) || sum_n[SUM_W-1] || (sum_n == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_interp_reg <= interp_mode_reg;
            a_t_reg      <= s_data.temperature;
            a_tmin_reg   <= a_tmin_next;
            a_tmax_reg   <= a_tmax_next;
            a_tg_reg     <= a_tg_next;
            a_ms_reg     <= a_ms_next;
            a_tag_reg    <= a_tag_next;

            b_simple_reg <= (a_interp_reg != INTERP_LINEAR) || (a_t_reg >= a_tmax_reg);
            b_sval_reg   <= (a_interp_reg != INTERP_LINEAR) ? a_tg_reg : a_ms_reg;
            b_den_reg    <= DIFF_W'(a_tmax_reg) - DIFF_W'(a_tmin_reg);
            b_dt_reg     <= DIFF_W'(a_t_reg) - DIFF_W'(a_tmin_reg);
            b_dms_reg    <= $signed({1'b0, a_ms_reg}) - $signed({1'b0, a_tg_reg});
            b_tg_reg     <= a_tg_reg;
            b_tag_reg    <= a_tag_reg;

            c_simple_reg <= b_simple_reg;
            c_sval_reg   <= b_sval_reg;
            c_den_reg    <= b_den_reg;
            c_p1_reg     <= PROD_W'($signed({1'b0, b_tg_reg})) * PROD_W'(b_den_reg);
            c_p2_reg     <= PROD_W'(b_dms_reg) * PROD_W'(b_dt_reg);
            c_tag_reg    <= b_tag_reg;

            d_num_reg    <= d_num_next;
            d_den_reg    <= d_den_next;
            d_tag_reg    <= d_tag_next;
        end
    end

    logic           div_valid;
    logic [Q_W-1:0] div_q;
    tag_t           div_tag;

    fci_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (d_valid_reg),
        .in_num    (d_num_reg),
        .in_den    (d_den_reg),
        .in_tag    (d_tag_reg),
        .out_valid (div_valid),
        .out_q     (div_q),
        .out_tag   (div_tag)
    );

    logic m_valid_reg;
    out_t m_data_reg;
    out_t m_data_next;

    always_comb begin
        m_data_next.safety_override = div_tag.ovr;
        if (div_tag.fixed) begin
            m_data_next.duty = div_tag.duty;
        end else if (div_tag.zero) begin
            m_data_next.duty = '0;
        end else begin
            m_data_next.duty = DUTY_W'(div_q);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `FCI_ASSERT_IMP(a_ovr_duty, aclk, aresetn, m_valid && m_data.safety_override, m_data.duty == DUTY_HOT || m_data.duty == DUTY_COLD, "override transaction carries a non-limit duty")
    `FCI_ASSERT_IMP(a_duty_range, aclk, aresetn, m_valid && !m_data.safety_override, m_data.duty <= DUTY_MAX, "duty above 255 without override")
    `FCI_ASSERT_IMP(a_empty_ready, aclk, aresetn, !m_valid, s_ready, "input blocked while output is empty")
    `FCI_ASSERT_NXT(a_stall_hold, aclk, aresetn, !s_ready, $stable(m_data), "output changed during a stall")

endmodule
